// ===== rtl/core/tlws_pkg.sv =====
// shared constants, codes and types of the text line wrap scrollback block
// no dependencies; used by the top level, tlws_csr, tlws_ctrl and tlws_dp
package tlws_pkg;

   localparam int LINES_DEF      = 256;
   localparam int LINE_CHARS_DEF = 128;

   localparam logic [7:0] WIDTH_RESET = 8'd90;

   // item function codes
   localparam logic [1:0] FUNC_CHAR  = 2'd0;
   localparam logic [1:0] FUNC_EOT   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_DEL   = 8'd127;

   localparam int TAB_STOP = 4;

   // register map
   localparam int   CSR_ADDR_W         = 3;
   localparam int   CSR_DATA_W         = 32;
   localparam logic CSR_IDX_LINE_WIDTH = 1'b0;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] char_code;
      logic [7:0] line_index;
      logic [6:0] column;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic [7:0] line_length;
      logic [8:0] lines_held;
      logic       line_pushed;
   } rsp_item_type;

   typedef struct packed {
      logic capture;
      logic put_char;
      logic tab_init;
      logic put_space;
      logic clear;
      logic commit_rd;
      logic commit_wr;
      logic read_map;
      logic read_row;
      logic read_data;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       is_nl;
      logic       is_tab;
      logic       printable;
      logic       idx_ok;
      logic       tab_more;
      logic       wrap;
      logic       out_busy;
   } dp_status_type;

endpackage

// ===== rtl/core/tlws_req_if.sv =====
// input channel of the scrollback block: valid/ready plus one item
// depends on nothing
interface tlws_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] char_code;
   logic [7:0] line_index;
   logic [6:0] column;

   modport source(output valid, output func, output char_code, output line_index,
                  output column, input ready);
   modport sink(input valid, input func, input char_code, input line_index,
                input column, output ready);
endinterface

// ===== rtl/core/tlws_rsp_if.sv =====
// result channel of the scrollback block: valid/ready plus one result
// depends on nothing
interface tlws_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_char;
   logic [7:0] line_length;
   logic [8:0] lines_held;
   logic       line_pushed;

   modport source(output valid, output read_char, output line_length,
                  output lines_held, output line_pushed, input ready);
   modport sink(input valid, input read_char, input line_length,
                input lines_held, input line_pushed, output ready);
endinterface

// ===== rtl/core/text_line_wrap_scrollback.sv =====
// top level of the text line wrap scrollback block
// depends on tlws_pkg, tlws_req_if, tlws_rsp_if, tlws_csr, tlws_ctrl, tlws_dp
//
// Takes one beat per item and returns exactly one result beat per item. An item
// is handled alone, stepped by a sequencer that writes at most one character a
// cycle into a single-port character store. A byte that is not printable is
// dropped; a tab writes up to 4 spaces; a newline or end of text commits the line
// through a slot map read and a row swap, and a wrap adds that read and swap to
// its byte or tab. A read of a held line steps through map, row and data reads; a
// clear or a read past the held lines goes straight to the result. Lines are kept
// in LINES+1 physical rows of 2**clog2(LINE_CHARS) bytes; the line being assembled
// fills the spare row and a commit only remaps it into the ring, so no characters
// are copied. There is no clearing pass after reset. A new item is accepted while
// the previous result waits in the output register; the item then holds in its
// last step until that register empties. line_width lives at byte address 0 of
// the csr port.
module text_line_wrap_scrollback #(
   parameter int LINES      = tlws_pkg::LINES_DEF,
   parameter int LINE_CHARS = tlws_pkg::LINE_CHARS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tlws_req_if.sink                        req_ch,
   tlws_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tlws_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tlws_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tlws_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   localparam int CCW = $clog2(LINE_CHARS + 1);

   tlws_pkg::dp_cmd_type    cmd;
   tlws_pkg::dp_status_type status;
   tlws_pkg::req_item_type  req_item;
   tlws_pkg::rsp_item_type  rsp_item;
   logic [CCW-1:0]          width;
   logic                    ready;
   logic                    rsp_valid;

   assign req_item.func       = req_ch.func;
   assign req_item.char_code  = req_ch.char_code;
   assign req_item.line_index = req_ch.line_index;
   assign req_item.column     = req_ch.column;
   assign req_ch.ready        = ready;

   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.read_char   = rsp_item.read_char;
   assign rsp_ch.line_length = rsp_item.line_length;
   assign rsp_ch.lines_held  = rsp_item.lines_held;
   assign rsp_ch.line_pushed = rsp_item.line_pushed;

   tlws_csr #(
      .LINE_CHARS (LINE_CHARS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .width   (width)
   );

   tlws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlws_dp #(
      .LINES      (LINES),
      .LINE_CHARS (LINE_CHARS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .width     (width),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready)
   );

endmodule

// ===== rtl/core/tlws_csr.sv =====
// apb-style register port holding line_width and giving its clamped working value
// depends on tlws_pkg
module tlws_csr #(
   parameter int LINE_CHARS = tlws_pkg::LINE_CHARS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tlws_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tlws_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tlws_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [$clog2(LINE_CHARS+1)-1:0]   width
);
   localparam int CCW = $clog2(LINE_CHARS + 1);

   logic [7:0] width_ff;
   logic [7:0] width_in;
   logic       hit;
   logic [8:0] lw9;
   logic [8:0] w9;

   assign pready = 1'b1;
   assign hit    = (paddr[tlws_pkg::CSR_ADDR_W-1:2] == tlws_pkg::CSR_IDX_LINE_WIDTH);

   always_comb begin
      width_in = width_ff;
      if (psel && penable && pwrite && hit) begin
         width_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= tlws_pkg::WIDTH_RESET;
      end else begin
         width_ff <= width_in;
      end
   end

   assign prdata = hit ? tlws_pkg::CSR_DATA_W'(width_ff) : '0;

   // zero acts as one column, anything past the row size as the row size
   assign lw9 = 9'(width_ff);
   always_comb begin
      if (lw9 == 9'd0) begin
         w9 = 9'd1;
      end else if (lw9 > 9'(LINE_CHARS)) begin
         w9 = 9'(LINE_CHARS);
      end else begin
         w9 = lw9;
      end
   end
   assign width = CCW'(w9);

endmodule

// ===== rtl/core/tlws_ctrl.sv =====
// sequencer of the scrollback block: steps one item through decode, tab fill,
// line commit or stored read, then hands the result beat to the output register
// depends on tlws_pkg
module tlws_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tlws_pkg::dp_status_type status,
   output tlws_pkg::dp_cmd_type    cmd
);
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_DECODE = 10'b0000000010,
      ST_TAB    = 10'b0000000100,
      ST_CHECK  = 10'b0000001000,
      ST_COMMIT = 10'b0000010000,
      ST_SWAP   = 10'b0000100000,
      ST_RMAP   = 10'b0001000000,
      ST_RROW   = 10'b0010000000,
      ST_RDATA  = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.func)
               tlws_pkg::FUNC_CHAR: begin
                  if (status.is_nl) begin
                     state_in = ST_COMMIT;
                  end else if (status.is_tab) begin
                     cmd.tab_init = 1'b1;
                     state_in     = ST_TAB;
                  end else begin
                     cmd.put_char = status.printable;
                     state_in     = ST_CHECK;
                  end
               end
               tlws_pkg::FUNC_EOT: begin
                  state_in = ST_COMMIT;
               end
               tlws_pkg::FUNC_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_DONE;
               end
               tlws_pkg::FUNC_READ: begin
                  state_in = status.idx_ok ? ST_RMAP : ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_TAB: begin
            // one space per cycle until the tab stop or the line edge
            if (status.tab_more) begin
               cmd.put_space = 1'b1;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.wrap ? ST_COMMIT : ST_DONE;
         end
         ST_COMMIT: begin
            cmd.commit_rd = 1'b1;
            state_in      = ST_SWAP;
         end
         ST_SWAP: begin
            cmd.commit_wr = 1'b1;
            state_in      = ST_DONE;
         end
         ST_RMAP: begin
            cmd.read_map = 1'b1;
            state_in     = ST_RROW;
         end
         ST_RROW: begin
            cmd.read_row = 1'b1;
            state_in     = ST_RDATA;
         end
         ST_RDATA: begin
            cmd.read_data = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/tlws_dp.sv =====
// datapath of the scrollback block: character rows, line lengths, slot-to-row
// map, ring pointers and the result register; driven by tlws_ctrl commands
// depends on tlws_pkg
module tlws_dp #(
   parameter int LINES      = tlws_pkg::LINES_DEF,
   parameter int LINE_CHARS = tlws_pkg::LINE_CHARS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tlws_pkg::dp_cmd_type            cmd,
   output tlws_pkg::dp_status_type         status,
   input  tlws_pkg::req_item_type          req_item,
   input  logic [$clog2(LINE_CHARS+1)-1:0] width,
   output tlws_pkg::rsp_item_type          rsp_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready
);
   localparam int SW          = $clog2(LINES);
   localparam int HW          = $clog2(LINES + 1);
   localparam int CW          = $clog2(LINE_CHARS);
   localparam int CCW         = $clog2(LINE_CHARS + 1);
   localparam int SUMW        = ((SW > 8) ? SW : 8) + 1;
   localparam int CHARS_DEPTH = (LINES + 1) * (2 ** CW);

   // one spare row beyond the ring: the line being assembled lives there and
   // trades places with the ring slot it commits to
   logic [7:0]    chars_mem [CHARS_DEPTH];
   logic [7:0]    len_mem   [LINES + 1];
   logic [HW-1:0] map_mem   [LINES];

   tlws_pkg::req_item_type item_ff;
   tlws_pkg::rsp_item_type rsp_ff;

   logic [CCW-1:0] cur_ff,      cur_in;
   logic [HW-1:0]  held_ff,     held_in;
   logic [SW-1:0]  oldest_ff,   oldest_in;
   logic [HW-1:0]  fill_ff,     fill_in;
   logic [HW-1:0]  pend_row_ff, pend_row_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [2:0]     adv_ff;
   logic [SW-1:0]  slot_ff;
   logic [HW-1:0]  map_rd_ff;
   logic [7:0]     len_rd_ff;
   logic [7:0]     chr_rd_ff;
   logic [7:0]     rchar_ff;
   logic [7:0]     rlen_ff;
   logic           pushed_ff;

   logic [SUMW-1:0]  sum_read;
   logic [SUMW-1:0]  sum_commit;
   logic [SW-1:0]    slot_read;
   logic [SW-1:0]    slot_commit;
   logic [SW-1:0]    map_raddr;
   logic             full;
   logic [HW-1:0]    mapped_row;
   logic [CCW-1:0]   line_len;
   logic [7:0]       len8;
   logic [SW-1:0]    oldest_next;
   logic [HW+CW-1:0] wr_addr;
   logic [HW+CW-1:0] rd_addr;
   logic [CW-1:0]    col_idx;

   function automatic logic [SW-1:0] ring_wrap(input logic [SUMW-1:0] x);
      logic [SUMW-1:0] y;
      y = (x >= SUMW'(LINES)) ? (x - SUMW'(LINES)) : x;
      return SW'(y);
   endfunction

   assign full        = (held_ff >= HW'(LINES));
   assign sum_read    = SUMW'(oldest_ff) + SUMW'(item_ff.line_index);
   assign sum_commit  = SUMW'(oldest_ff) + SUMW'(held_ff);
   assign slot_read   = ring_wrap(sum_read);
   assign slot_commit = full ? oldest_ff : ring_wrap(sum_commit);
   assign map_raddr   = cmd.read_map ? slot_read : slot_commit;

   // slots at or above the fill mark were never remapped and still own their row
   assign mapped_row  = (HW'(slot_ff) < fill_ff) ? map_rd_ff : HW'(slot_ff);

   assign line_len    = (cur_ff > width) ? width : cur_ff;
   assign len8        = 8'(line_len);
   assign oldest_next = (oldest_ff == SW'(LINES - 1)) ? '0 : (oldest_ff + 1'b1);
   assign col_idx     = CW'(item_ff.column);
   assign wr_addr     = {pend_row_ff, cur_ff[CW-1:0]};
   assign rd_addr     = {mapped_row, col_idx};

   always_comb begin
      status.func      = item_ff.func;
      status.is_nl     = (item_ff.char_code == tlws_pkg::CHAR_NL);
      status.is_tab    = (item_ff.char_code == tlws_pkg::CHAR_TAB);
      status.printable = (item_ff.char_code inside
                          {[tlws_pkg::CHAR_SPACE:tlws_pkg::CHAR_DEL - 8'd1]})
                         && (cur_ff < CCW'(LINE_CHARS));
      status.idx_ok    = (SUMW'(item_ff.line_index) < SUMW'(held_ff));
      status.tab_more  = (adv_ff != 3'd0) && (cur_ff < width);
      status.wrap      = (cur_ff >= width);
      status.out_busy  = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      cur_in       = cur_ff;
      held_in      = held_ff;
      oldest_in    = oldest_ff;
      fill_in      = fill_ff;
      pend_row_in  = pend_row_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.put_char || cmd.put_space) begin
         cur_in = cur_ff + 1'b1;
      end
      if (cmd.clear) begin
         held_in   = '0;
         oldest_in = '0;
      end
      if (cmd.commit_wr) begin
         cur_in      = '0;
         pend_row_in = mapped_row;
         if (full) begin
            oldest_in = oldest_next;
         end else begin
            held_in = held_ff + 1'b1;
         end
         if (HW'(slot_ff) == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         held_ff      <= '0;
         oldest_ff    <= '0;
         fill_ff      <= '0;
         pend_row_ff  <= HW'(LINES);
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         held_ff      <= held_in;
         oldest_ff    <= oldest_in;
         fill_ff      <= fill_in;
         pend_row_ff  <= pend_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff   <= req_item;
         pushed_ff <= 1'b0;
         rchar_ff  <= '0;
         rlen_ff   <= '0;
      end
      if (cmd.tab_init) begin
         adv_ff <= 3'(tlws_pkg::TAB_STOP) - {1'b0, cur_ff[1:0]};
      end
      if (cmd.put_space) begin
         adv_ff <= adv_ff - 3'd1;
      end
      if (cmd.commit_rd || cmd.read_map) begin
         slot_ff <= map_raddr;
      end
      if (cmd.commit_wr) begin
         pushed_ff <= 1'b1;
      end
      if (cmd.read_data) begin
         rlen_ff  <= len_rd_ff;
         rchar_ff <= ({1'b0, item_ff.column} < len_rd_ff) ? chr_rd_ff : '0;
      end
      if (cmd.load_out) begin
         rsp_ff.read_char   <= rchar_ff;
         rsp_ff.line_length <= rlen_ff;
         rsp_ff.lines_held  <= 9'(held_ff);
         rsp_ff.line_pushed <= pushed_ff;
      end
   end

   // slot-to-row map
   always_ff @(posedge clock) begin
      if (cmd.commit_rd || cmd.read_map) begin
         map_rd_ff <= map_mem[map_raddr];
      end
      if (cmd.commit_wr) begin
         map_mem[slot_ff] <= pend_row_ff;
      end
   end

   // line lengths, one per physical row
   always_ff @(posedge clock) begin
      if (cmd.commit_wr) begin
         len_mem[pend_row_ff] <= len8;
      end
      if (cmd.read_row) begin
         len_rd_ff <= len_mem[mapped_row];
      end
   end

   // character rows
   always_ff @(posedge clock) begin
      if (cmd.put_char || cmd.put_space) begin
         chars_mem[wr_addr] <= cmd.put_space ? tlws_pkg::CHAR_SPACE : item_ff.char_code;
      end
      if (cmd.read_row) begin
         chr_rd_ff <= chars_mem[rd_addr];
      end
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_commit_slot_mapped: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_wr |-> (HW'(slot_ff) <= fill_ff))
      else $error("commit slot lies beyond the map fill mark");

   a_commit_resets_col: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_wr |=> (cur_ff == '0))
      else $error("column not reset after line commit");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (held_ff == '0) && (oldest_ff == '0))
      else $error("ring not empty after clear");

   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register loaded while a beat still waits");

endmodule
